[hw/rtl/cds_pkg.sv]
// Shared types, constants, calendar functions and microcode for the date stepper.
package cds_pkg;

   localparam int STEP_WIDTH = 16;
   localparam int PC_WIDTH = 4;
   localparam int DAY_WIDTH = 5;
   localparam int MONTH_WIDTH = 4;
   localparam int YEAR_WIDTH = 14;
   localparam int DIST_WIDTH = 22;
   localparam int REC_SHIFT = 19;

   localparam logic [YEAR_WIDTH-1:0] YEAR_MIN = 14'd1;
   localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = 14'd9999;
   localparam logic [MONTH_WIDTH-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_WIDTH-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_WIDTH-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_WIDTH-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_WIDTH-1:0] DAY_FIRST = 5'd1;
   localparam logic [DAY_WIDTH-1:0] DAY_LAST_DEC = 5'd31;
   localparam logic [12:0] REC_100 = 13'd5243;
   localparam logic [DIST_WIDTH-1:0] DAYS_PER_YEAR = 22'd365;
   localparam logic [DIST_WIDTH-1:0] DAY_BIAS = 22'd306;

   localparam logic [PC_WIDTH-1:0] ADDR_CHECK = 4'd0;
   localparam logic [PC_WIDTH-1:0] ADDR_LOAD = 4'd1;
   localparam logic [PC_WIDTH-1:0] ADDR_STEP = 4'd2;
   localparam logic [PC_WIDTH-1:0] ADDR_LOOP = 4'd3;
   localparam logic [PC_WIDTH-1:0] ADDR_FINISH = 4'd4;
   localparam logic [PC_WIDTH-1:0] ADDR_DIST = 4'd5;
   localparam logic [PC_WIDTH-1:0] ADDR_DN_CUR1 = 4'd6;
   localparam logic [PC_WIDTH-1:0] ADDR_DN_CUR2 = 4'd7;
   localparam logic [PC_WIDTH-1:0] ADDR_DN_IN1 = 4'd8;
   localparam logic [PC_WIDTH-1:0] ADDR_DN_IN2 = 4'd9;
   localparam logic [PC_WIDTH-1:0] ADDR_DIFF = 4'd10;

   typedef enum logic [1:0] {
      ACT_LOAD = 2'd0,
      ACT_FWD  = 2'd1,
      ACT_BACK = 2'd2,
      ACT_DIST = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_CHECK,
      OP_LOAD,
      OP_STEP,
      OP_DN1,
      OP_DN2,
      OP_DIFF,
      OP_FINISH
   } op_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_DISPATCH,
      C_CUR_BAD,
      C_STEP_MORE,
      C_DIST_SKIP
   } cond_type;

   typedef struct packed {
      op_type op;
      logic sel_in;
      cond_type cond;
      logic [PC_WIDTH-1:0] target;
   } uword_type;

   typedef struct packed {
      op_type op;
      logic sel_in;
   } dp_ctrl_type;

   typedef struct packed {
      action_type action;
      logic in_ok;
      logic cur_ok;
      logic step_more;
   } dp_stat_type;

   function automatic logic leap_year(input logic [YEAR_WIDTH-1:0] y);
      logic [26:0] prod;
      logic [7:0] q;
      logic [YEAR_WIDTH-1:0] r;
      prod = 27'(y) * 27'(REC_100);
      q = prod[26:REC_SHIFT];
      r = y - YEAR_WIDTH'(q) * 14'd100;
      return ((y[1:0] == 2'd0) && (r != '0)) || ((r == '0) && (q[1:0] == 2'd0));
   endfunction

   function automatic logic [DAY_WIDTH-1:0] month_len(input logic [MONTH_WIDTH-1:0] m,
                                                     input logic leap);
      logic [DAY_WIDTH-1:0] len;
      case (m)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic valid_date(input logic [DAY_WIDTH-1:0] d,
                                       input logic [MONTH_WIDTH-1:0] m,
                                       input logic [YEAR_WIDTH-1:0] y);
      logic ok;
      ok = (y >= YEAR_MIN) && (y <= YEAR_MAX) && (m >= MONTH_JAN) && (m <= MONTH_DEC)
           && (d >= DAY_FIRST) && (d <= month_len(m, leap_year(y)));
      return ok;
   endfunction

   function automatic logic [8:0] month_offset(input logic [MONTH_WIDTH-1:0] m);
      logic [8:0] off;
      case (m)
         4'd1:    off = 9'd306;
         4'd2:    off = 9'd337;
         4'd3:    off = 9'd0;
         4'd4:    off = 9'd31;
         4'd5:    off = 9'd61;
         4'd6:    off = 9'd92;
         4'd7:    off = 9'd122;
         4'd8:    off = 9'd153;
         4'd9:    off = 9'd184;
         4'd10:   off = 9'd214;
         4'd11:   off = 9'd245;
         4'd12:   off = 9'd275;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

   function automatic uword_type ucode(input logic [PC_WIDTH-1:0] pc);
      uword_type w;
      case (pc)
         ADDR_CHECK:   w = '{OP_CHECK,  1'b0, C_DISPATCH,  ADDR_LOAD};
         ADDR_LOAD:    w = '{OP_LOAD,   1'b1, C_ALWAYS,    ADDR_FINISH};
         ADDR_STEP:    w = '{OP_NOP,    1'b0, C_CUR_BAD,   ADDR_FINISH};
         ADDR_LOOP:    w = '{OP_STEP,   1'b0, C_STEP_MORE, ADDR_LOOP};
         ADDR_FINISH:  w = '{OP_FINISH, 1'b0, C_NEXT,      ADDR_CHECK};
         ADDR_DIST:    w = '{OP_NOP,    1'b0, C_DIST_SKIP, ADDR_FINISH};
         ADDR_DN_CUR1: w = '{OP_DN1,    1'b0, C_NEXT,      ADDR_CHECK};
         ADDR_DN_CUR2: w = '{OP_DN2,    1'b0, C_NEXT,      ADDR_CHECK};
         ADDR_DN_IN1:  w = '{OP_DN1,    1'b1, C_NEXT,      ADDR_CHECK};
         ADDR_DN_IN2:  w = '{OP_DN2,    1'b1, C_NEXT,      ADDR_CHECK};
         ADDR_DIFF:    w = '{OP_DIFF,   1'b0, C_ALWAYS,    ADDR_FINISH};
         default:      w = '{OP_FINISH, 1'b0, C_NEXT,      ADDR_CHECK};
      endcase
      return w;
   endfunction

endpackage

[hw/rtl/cds_sequencer.sv]
// Microcode sequencer: step counter, control ROM and conditional jumps.
module cds_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  cds_pkg::dp_stat_type  stat,
   output cds_pkg::dp_ctrl_type  ctrl,
   output logic                  busy
);

   logic                         running_ff, running_in;
   logic [cds_pkg::PC_WIDTH-1:0] pc_ff, pc_in;
   cds_pkg::uword_type           word;
   logic                         taken;
   logic [cds_pkg::PC_WIDTH-1:0] target;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         pc_ff      <= cds_pkg::ADDR_CHECK;
      end else begin
         running_ff <= running_in;
         pc_ff      <= pc_in;
      end
   end

   always_comb begin
      word   = cds_pkg::ucode(pc_ff);
      taken  = 1'b0;
      target = word.target;
      case (word.cond)
         cds_pkg::C_NEXT:      taken = 1'b0;
         cds_pkg::C_ALWAYS:    taken = 1'b1;
         cds_pkg::C_DISPATCH: begin
            taken = 1'b1;
            case (stat.action)
               cds_pkg::ACT_LOAD: target = cds_pkg::ADDR_LOAD;
               cds_pkg::ACT_FWD:  target = cds_pkg::ADDR_STEP;
               cds_pkg::ACT_BACK: target = cds_pkg::ADDR_STEP;
               default:           target = cds_pkg::ADDR_DIST;
            endcase
         end
         cds_pkg::C_CUR_BAD:   taken = !stat.cur_ok;
         cds_pkg::C_STEP_MORE: taken = stat.step_more;
         cds_pkg::C_DIST_SKIP: taken = !(stat.in_ok && stat.cur_ok);
         default:              taken = 1'b0;
      endcase

      running_in = running_ff;
      pc_in      = pc_ff;
      if (!running_ff) begin
         if (accept) begin
            running_in = 1'b1;
            pc_in      = cds_pkg::ADDR_CHECK;
         end
      end else if (word.op == cds_pkg::OP_FINISH) begin
         running_in = 1'b0;
      end else begin
         pc_in = taken ? target : pc_ff + 1'b1;
      end

      ctrl.op     = running_ff ? word.op : cds_pkg::OP_NOP;
      ctrl.sel_in = word.sel_in;
   end

   assign busy = running_ff;

endmodule

[hw/rtl/cds_datapath.sv]
// Datapath: stored date, step count, day-number arithmetic and result registers.
module cds_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [1:0]                      req_action,
   input  logic [cds_pkg::DAY_WIDTH-1:0]   req_in_day,
   input  logic [cds_pkg::MONTH_WIDTH-1:0] req_in_month,
   input  logic [cds_pkg::YEAR_WIDTH-1:0]  req_in_year,
   input  logic [15:0]                     req_step_count,
   input  cds_pkg::dp_ctrl_type            ctrl,
   output cds_pkg::dp_stat_type            stat,
   output logic                            rsp_strobe,
   output logic [cds_pkg::DAY_WIDTH-1:0]   rsp_out_day,
   output logic [cds_pkg::MONTH_WIDTH-1:0] rsp_out_month,
   output logic [cds_pkg::YEAR_WIDTH-1:0]  rsp_out_year,
   output logic                            rsp_date_ok,
   output logic                            rsp_range_error,
   output logic [cds_pkg::DIST_WIDTH-1:0]  rsp_distance
);

   logic [cds_pkg::DAY_WIDTH-1:0]   cur_day_ff, cur_day_in;
   logic [cds_pkg::MONTH_WIDTH-1:0] cur_month_ff, cur_month_in;
   logic [cds_pkg::YEAR_WIDTH-1:0]  cur_year_ff, cur_year_in;
   logic [cds_pkg::STEP_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                            strobe_ff;
   cds_pkg::action_type             action_ff;
   logic [cds_pkg::DAY_WIDTH-1:0]   in_day_ff;
   logic [cds_pkg::MONTH_WIDTH-1:0] in_month_ff;
   logic [cds_pkg::YEAR_WIDTH-1:0]  in_year_ff;
   logic                            in_ok_ff, cur_ok_ff, ok_ff, rerr_ff;
   logic [6:0]                      q100_ff;
   logic [cds_pkg::DIST_WIDTH-1:0]  base_ff, acc_a_ff, acc_b_ff, dist_ff;

   logic                            leap_cur, movable, back_dir;
   logic [cds_pkg::DAY_WIDTH-1:0]   mlen_cur, mlen_prev, nx_day;
   logic [cds_pkg::MONTH_WIDTH-1:0] nx_month;
   logic [cds_pkg::YEAR_WIDTH-1:0]  nx_year;
   logic [cds_pkg::DAY_WIDTH-1:0]   src_day;
   logic [cds_pkg::MONTH_WIDTH-1:0] src_month;
   logic [cds_pkg::YEAR_WIDTH-1:0]  src_year, shift_year;
   logic [26:0]                     q_prod;
   logic [cds_pkg::DIST_WIDTH-1:0]  base_val, dn_val;

   always_comb begin
      back_dir  = (action_ff == cds_pkg::ACT_BACK);
      leap_cur  = cds_pkg::leap_year(cur_year_ff);
      mlen_cur  = cds_pkg::month_len(cur_month_ff, leap_cur);
      mlen_prev = cds_pkg::month_len(cur_month_ff - 1'b1, leap_cur);
      nx_day    = cur_day_ff;
      nx_month  = cur_month_ff;
      nx_year   = cur_year_ff;
      movable   = 1'b1;
      if (!back_dir) begin
         if (cur_day_ff < mlen_cur) begin
            nx_day = cur_day_ff + 1'b1;
         end else if (cur_month_ff < cds_pkg::MONTH_DEC) begin
            nx_day   = cds_pkg::DAY_FIRST;
            nx_month = cur_month_ff + 1'b1;
         end else if (cur_year_ff < cds_pkg::YEAR_MAX) begin
            nx_day   = cds_pkg::DAY_FIRST;
            nx_month = cds_pkg::MONTH_JAN;
            nx_year  = cur_year_ff + 1'b1;
         end else begin
            movable = 1'b0;
         end
      end else begin
         if (cur_day_ff > cds_pkg::DAY_FIRST) begin
            nx_day = cur_day_ff - 1'b1;
         end else if (cur_month_ff > cds_pkg::MONTH_JAN) begin
            nx_month = cur_month_ff - 1'b1;
            nx_day   = mlen_prev;
         end else if (cur_year_ff > cds_pkg::YEAR_MIN) begin
            nx_year  = cur_year_ff - 1'b1;
            nx_month = cds_pkg::MONTH_DEC;
            nx_day   = cds_pkg::DAY_LAST_DEC;
         end else begin
            movable = 1'b0;
         end
      end

      src_day    = ctrl.sel_in ? in_day_ff : cur_day_ff;
      src_month  = ctrl.sel_in ? in_month_ff : cur_month_ff;
      src_year   = ctrl.sel_in ? in_year_ff : cur_year_ff;
      shift_year = (src_month < cds_pkg::MONTH_MAR) ? src_year - 1'b1 : src_year;
      q_prod     = 27'(shift_year) * 27'(cds_pkg::REC_100);
      base_val   = cds_pkg::DIST_WIDTH'(shift_year) * cds_pkg::DAYS_PER_YEAR
                   + cds_pkg::DIST_WIDTH'(shift_year >> 2)
                   + cds_pkg::DIST_WIDTH'(cds_pkg::month_offset(src_month))
                   + cds_pkg::DIST_WIDTH'(src_day);
      dn_val     = base_ff + cds_pkg::DIST_WIDTH'(q100_ff >> 2)
                   - cds_pkg::DIST_WIDTH'(q100_ff) - cds_pkg::DAY_BIAS;

      cur_day_in   = cur_day_ff;
      cur_month_in = cur_month_ff;
      cur_year_in  = cur_year_ff;
      cnt_in       = cnt_ff;
      if (accept) begin
         cnt_in = cds_pkg::STEP_WIDTH'(req_step_count);
      end
      case (ctrl.op)
         cds_pkg::OP_LOAD: begin
            if (in_ok_ff) begin
               cur_day_in   = in_day_ff;
               cur_month_in = in_month_ff;
               cur_year_in  = in_year_ff;
            end
         end
         cds_pkg::OP_STEP: begin
            if (cnt_ff != '0) begin
               if (movable) begin
                  cur_day_in   = nx_day;
                  cur_month_in = nx_month;
                  cur_year_in  = nx_year;
                  cnt_in       = cnt_ff - 1'b1;
               end else begin
                  cnt_in = '0;
               end
            end
         end
         cds_pkg::OP_FINISH: cnt_in = '0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_day_ff   <= '0;
         cur_month_ff <= '0;
         cur_year_ff  <= '0;
         cnt_ff       <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         cur_day_ff   <= cur_day_in;
         cur_month_ff <= cur_month_in;
         cur_year_ff  <= cur_year_in;
         cnt_ff       <= cnt_in;
         strobe_ff    <= (ctrl.op == cds_pkg::OP_FINISH);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff   <= cds_pkg::action_type'(req_action);
         in_day_ff   <= req_in_day;
         in_month_ff <= req_in_month;
         in_year_ff  <= req_in_year;
      end
      case (ctrl.op)
         cds_pkg::OP_CHECK: begin
            in_ok_ff  <= cds_pkg::valid_date(in_day_ff, in_month_ff, in_year_ff);
            cur_ok_ff <= cds_pkg::valid_date(cur_day_ff, cur_month_ff, cur_year_ff);
            ok_ff     <= (action_ff == cds_pkg::ACT_FWD || action_ff == cds_pkg::ACT_BACK)
                         ? cds_pkg::valid_date(cur_day_ff, cur_month_ff, cur_year_ff)
                         : cds_pkg::valid_date(in_day_ff, in_month_ff, in_year_ff);
            rerr_ff   <= 1'b0;
            dist_ff   <= '0;
         end
         cds_pkg::OP_STEP: begin
            if (cnt_ff != '0 && !movable) begin
               rerr_ff <= 1'b1;
            end
         end
         cds_pkg::OP_DN1: begin
            q100_ff <= q_prod[25:cds_pkg::REC_SHIFT];
            base_ff <= base_val;
         end
         cds_pkg::OP_DN2: begin
            acc_a_ff <= dn_val;
            acc_b_ff <= acc_a_ff;
         end
         cds_pkg::OP_DIFF: begin
            dist_ff <= (acc_a_ff >= acc_b_ff) ? acc_a_ff - acc_b_ff : acc_b_ff - acc_a_ff;
         end
         default: ;
      endcase
   end

   assign stat.action    = action_ff;
   assign stat.in_ok     = in_ok_ff;
   assign stat.cur_ok    = cur_ok_ff;
   assign stat.step_more = (cnt_ff > cds_pkg::STEP_WIDTH'(1)) && movable;

   assign rsp_strobe      = strobe_ff;
   assign rsp_out_day     = cur_day_ff;
   assign rsp_out_month   = cur_month_ff;
   assign rsp_out_year    = cur_year_ff;
   assign rsp_date_ok     = ok_ff;
   assign rsp_range_error = rerr_ff;
   assign rsp_distance    = dist_ff;

endmodule

[hw/rtl/calendar_date_stepper_top.sv]
// Top level of the calendar date stepper: sequencer and datapath.
//
// A request is taken when start is high and busy is low; its response appears for
// one cycle with rsp_strobe and cannot be held off, and the next request may be
// taken in that same cycle. A forward or backward step runs for the step count,
// stops early when a year limit is reached and skips the loop when no date is
// stored; a distance skips the day-number work when either date is invalid.
// Stepping advances one day per cycle in a single-instruction loop, and each day
// number takes two steps of the shared day-number datapath. No clearing pass
// follows reset.
module calendar_date_stepper_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_action,
   input  logic [cds_pkg::DAY_WIDTH-1:0]   req_in_day,
   input  logic [cds_pkg::MONTH_WIDTH-1:0] req_in_month,
   input  logic [cds_pkg::YEAR_WIDTH-1:0]  req_in_year,
   input  logic [15:0]                     req_step_count,
   output logic                            rsp_strobe,
   output logic [cds_pkg::DAY_WIDTH-1:0]   rsp_out_day,
   output logic [cds_pkg::MONTH_WIDTH-1:0] rsp_out_month,
   output logic [cds_pkg::YEAR_WIDTH-1:0]  rsp_out_year,
   output logic                            rsp_date_ok,
   output logic                            rsp_range_error,
   output logic [cds_pkg::DIST_WIDTH-1:0]  rsp_distance
);

   logic                 accept;
   cds_pkg::dp_ctrl_type ctrl;
   cds_pkg::dp_stat_type stat;

   assign accept = start && !busy;

   cds_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .stat   (stat),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   cds_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_action      (req_action),
      .req_in_day      (req_in_day),
      .req_in_month    (req_in_month),
      .req_in_year     (req_in_year),
      .req_step_count  (req_step_count),
      .ctrl            (ctrl),
      .stat            (stat),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_day     (rsp_out_day),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_year    (rsp_out_year),
      .rsp_date_ok     (rsp_date_ok),
      .rsp_range_error (rsp_range_error),
      .rsp_distance    (rsp_distance)
   );

endmodule

[hw/rtl/cds_checker.sv]
// Port-level checker for the date stepper and its bind to the top level.
module cds_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_strobe,
   input logic                            rsp_date_ok,
   input logic                            rsp_range_error,
   input logic [cds_pkg::DIST_WIDTH-1:0]  rsp_distance
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while busy");

   a_flags_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_range_error || rsp_distance != '0)) |-> rsp_date_ok)
      else $error("range error or distance without valid date");

endmodule

bind calendar_date_stepper_top cds_checker u_cds_checker (.*);
